// ===== hdl/grid_astar_path_search_defines.svh =====
// Assertion macros for the grid path search.
`ifndef GRID_ASTAR_PATH_SEARCH_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GASP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define GASP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define GASP_ASSERT(lbl, prop)
`define GASP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/gasp_pkg.sv =====
`timescale 1ns / 1ps
package gasp_pkg;
	localparam int COORD_W = 3;
	localparam int COST_W = 8;
	localparam int PCOST_W = 14;
	localparam int F_W = 15;
	localparam int SIZE_W = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SEARCH = 1'b1;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [1:0] DIR_UP = 2'd3;

	typedef logic [2*COORD_W-1:0] coord_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_START, S_SCAN, S_PICK, S_NB, S_NBCMP,
		S_TRPUSH, S_TRWAIT, S_EMRD, S_EMLD, S_NOPATH
	} state_t;
endpackage

// ===== hdl/gasp_ram.sv =====
`timescale 1ns / 1ps
module gasp_ram #(
	parameter int DW = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/grid_astar_path_search.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata (low bit up)                          tuser    tlast
// s_*      in   cell_x, cell_y, cell_cost, goal_x, goal_y     opcode   -
// m_*      out  path_x, path_y, path_cost                     no_path  last
// cfg_*    in   index 0 grid_width, 1 grid_height; data 4 bits
// A load writes one cell. A search scans all cells, then does neighbor work per
// expansion through one best-cost RAM port, then traces the path back cell by cell
// and emits one result per path cell. Reset clears control only.
// s_tready is high only between searches; a result waits in the output register.
`include "grid_astar_path_search_defines.svh"
module grid_astar_path_search
	import gasp_pkg::*;
#(
	parameter int GRID_MAX_WIDTH = 8,
	parameter int GRID_MAX_HEIGHT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // cell_x, cell_y, cell_cost, goal_x, goal_y, zero pad
	input  logic        s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // path_x, path_y, path_cost, zero pad
	output logic        m_tuser,  // no_path
	output logic        m_tlast,  // last
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	localparam int CELLS = GRID_MAX_WIDTH * GRID_MAX_HEIGHT;
	localparam int IW = $clog2(CELLS);

	function automatic logic [IW-1:0] cidx(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		return IW'(int'(y) * GRID_MAX_WIDTH + int'(x));
	endfunction

	function automatic logic [SIZE_W-1:0] clampsz(logic [SIZE_W-1:0] v, int mx);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_W'(1);
		else if (int'(v) > mx) r = SIZE_W'(mx);
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] adist(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	logic [COORD_W-1:0] in_x, in_y, in_gx, in_gy;
	logic [COST_W-1:0]  in_cost;
	assign in_x = s_tdata[2:0];
	assign in_y = s_tdata[5:3];
	assign in_cost = s_tdata[13:6];
	assign in_gx = s_tdata[16:14];
	assign in_gy = s_tdata[19:17];

	state_t state_q, state_d;

	logic [SIZE_W-1:0] width_q, height_q, w_q, h_q;
	logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;
	logic [CELLS-1:0] open_q, bval_q;

	logic [COORD_W-1:0] scx_q, scy_q;
	logic [IW-1:0] sci_q;
	logic sc_end_q;
	logic vld_s1;
	logic [COORD_W-1:0] x_s1, y_s1;

	logic found_q;
	logic [F_W-1:0] bestf_q;
	logic [PCOST_W-1:0] bestg_q, pcost_q;
	logic [COORD_W-1:0] curx_q, cury_q;
	logic [1:0] dir_q;
	logic [COORD_W-1:0] nbx_q, nby_q;

	coord_t tcur_q;
	logic [IW-1:0] n_q, ei_q;

	logic ovalid_q;
	logic [23:0] odata_q;
	logic onopath_q, olast_q;

	// RAM ports
	logic cost_we, best_we, cf_we, stk_we;
	logic [IW-1:0] cost_waddr, cost_raddr, best_waddr, best_raddr, cf_raddr;
	logic [COST_W-1:0] cost_wdata, cost_rd;
	logic [PCOST_W-1:0] best_wdata, best_rd;
	coord_t cf_wdata, cf_rd, stk_rd;
	logic [IW-1:0] cf_waddr, stk_waddr, stk_raddr;

	gasp_ram #(.DW(COST_W), .DEPTH(CELLS)) u_cost (
		.clk, .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.raddr(cost_raddr), .rdata(cost_rd));
	gasp_ram #(.DW(PCOST_W), .DEPTH(CELLS)) u_best (
		.clk, .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
		.raddr(best_raddr), .rdata(best_rd));
	gasp_ram #(.DW(2*COORD_W), .DEPTH(CELLS)) u_cf (
		.clk, .we(cf_we), .waddr(cf_waddr), .wdata(cf_wdata),
		.raddr(cf_raddr), .rdata(cf_rd));
	gasp_ram #(.DW(2*COORD_W), .DEPTH(CELLS)) u_stk (
		.clk, .we(stk_we), .waddr(stk_waddr), .wdata(tcur_q),
		.raddr(stk_raddr), .rdata(stk_rd));

	logic in_xfer, oload, ofree;
	logic [SIZE_W-1:0] cw, ch;
	logic nb_ok;
	logic [COORD_W-1:0] nbx, nby;
	logic [F_W-1:0] f_s1;
	logic [F_W-1:0] g_new;
	logic [PCOST_W-1:0] best_eff;
	logic is_goal, at_start;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer = s_tvalid && s_tready;
	assign ofree = !ovalid_q || m_tready;
	assign cw = clampsz(width_q, GRID_MAX_WIDTH);
	assign ch = clampsz(height_q, GRID_MAX_HEIGHT);

	assign f_s1 = F_W'(best_rd) + F_W'(adist(x_s1, gx_q)) + F_W'(adist(y_s1, gy_q));
	assign g_new = F_W'(bestg_q) + F_W'(cost_rd);
	assign best_eff = bval_q[cidx(nbx_q, nby_q)] ? best_rd : '1;
	assign is_goal = (curx_q == gx_q) && (cury_q == gy_q);
	assign at_start = (tcur_q == {sy_q, sx_q});

	always_comb begin
		nb_ok = 1'b0;
		nbx = curx_q;
		nby = cury_q;
		case (dir_q)
			2'd0: begin
				nb_ok = (SIZE_W'(curx_q) + SIZE_W'(1)) < w_q;
				nbx = curx_q + COORD_W'(1);
			end
			2'd1: begin
				nb_ok = (SIZE_W'(cury_q) + SIZE_W'(1)) < h_q;
				nby = cury_q + COORD_W'(1);
			end
			2'd2: begin
				nb_ok = curx_q != '0;
				nbx = curx_q - COORD_W'(1);
			end
			default: begin
				nb_ok = cury_q != '0;
				nby = cury_q - COORD_W'(1);
			end
		endcase
	end

	always_comb begin
		cost_we = in_xfer && (s_tuser == OP_LOAD) && (int'(in_x) < GRID_MAX_WIDTH)
			&& (int'(in_y) < GRID_MAX_HEIGHT);
		cost_waddr = cidx(in_x, in_y);
		cost_wdata = in_cost;
		cost_raddr = (state_q == S_NB) ? cidx(nbx, nby) : cidx(sx_q, sy_q);
		best_raddr = (state_q == S_SCAN) ? sci_q : cidx(nbx, nby);
		best_we = 1'b0;
		best_waddr = cidx(nbx_q, nby_q);
		best_wdata = PCOST_W'(g_new);
		cf_we = 1'b0;
		cf_waddr = cidx(nbx_q, nby_q);
		cf_wdata = {cury_q, curx_q};
		cf_raddr = cidx(tcur_q[COORD_W-1:0], tcur_q[2*COORD_W-1:COORD_W]);
		stk_we = (state_q == S_TRPUSH);
		stk_waddr = n_q;
		stk_raddr = ei_q;
		oload = 1'b0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && s_tuser == OP_SEARCH) begin
					if (SIZE_W'(in_x) >= cw || SIZE_W'(in_y) >= ch ||
					    SIZE_W'(in_gx) >= cw || SIZE_W'(in_gy) >= ch) state_d = S_NOPATH;
					else state_d = S_INIT;
				end
			end
			S_INIT: state_d = S_START;
			S_START: begin
				best_we = 1'b1;
				best_waddr = cidx(sx_q, sy_q);
				best_wdata = PCOST_W'(cost_rd);
				cf_we = 1'b1;
				cf_waddr = cidx(sx_q, sy_q);
				cf_wdata = {sy_q, sx_q};
				state_d = S_SCAN;
			end
			S_SCAN: if (sc_end_q) state_d = S_PICK;
			S_PICK: begin
				if (!found_q) state_d = S_NOPATH;
				else if (is_goal) state_d = S_TRPUSH;
				else state_d = S_NB;
			end
			S_NB: begin
				if (nb_ok) state_d = S_NBCMP;
				else if (dir_q == DIR_UP) state_d = S_SCAN;
			end
			S_NBCMP: begin
				if (g_new < F_W'(best_eff)) begin
					best_we = 1'b1;
					cf_we = 1'b1;
				end
				state_d = (dir_q == DIR_UP) ? S_SCAN : S_NB;
			end
			S_TRPUSH: begin
				if (at_start || n_q == IW'(CELLS - 1)) state_d = S_EMRD;
				else state_d = S_TRWAIT;
			end
			S_TRWAIT: state_d = S_TRPUSH;
			S_EMRD: state_d = S_EMLD;
			S_EMLD: begin
				if (ofree) begin
					oload = 1'b1;
					state_d = (ei_q == '0) ? S_IDLE : S_EMRD;
				end
			end
			S_NOPATH: begin
				if (ofree) begin
					oload = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_W'(8);
			height_q <= SIZE_W'(8);
			open_q <= '0;
			bval_q <= '0;
			sc_end_q <= 1'b0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			dir_q <= '0;
			n_q <= '0;
			ei_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			if (oload) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					open_q <= '0;
					bval_q <= '0;
				end
				S_START: begin
					open_q[cidx(sx_q, sy_q)] <= 1'b1;
					bval_q[cidx(sx_q, sy_q)] <= 1'b1;
					sc_end_q <= 1'b0;
					found_q <= 1'b0;
				end
				S_SCAN: begin
					if (!sc_end_q) begin
						vld_s1 <= open_q[sci_q];
						sc_end_q <= (sci_q == IW'(CELLS - 1));
					end
					if (vld_s1 && (!found_q || f_s1 < bestf_q)) found_q <= 1'b1;
				end
				S_PICK: begin
					dir_q <= '0;
					n_q <= '0;
					if (found_q && !is_goal) open_q[cidx(curx_q, cury_q)] <= 1'b0;
				end
				S_NB: begin
					if (!nb_ok) begin
						dir_q <= dir_q + 2'd1;
						if (dir_q == DIR_UP) begin
							sc_end_q <= 1'b0;
							found_q <= 1'b0;
						end
					end
				end
				S_NBCMP: begin
					dir_q <= dir_q + 2'd1;
					if (g_new < F_W'(best_eff)) begin
						open_q[cidx(nbx_q, nby_q)] <= 1'b1;
						bval_q[cidx(nbx_q, nby_q)] <= 1'b1;
					end
					if (dir_q == DIR_UP) begin
						sc_end_q <= 1'b0;
						found_q <= 1'b0;
					end
				end
				S_TRPUSH: begin
					n_q <= n_q + IW'(1);
					ei_q <= n_q;
				end
				S_EMLD: if (ofree && ei_q != '0) ei_q <= ei_q - IW'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer && s_tuser == OP_SEARCH) begin
			sx_q <= in_x;
			sy_q <= in_y;
			gx_q <= in_gx;
			gy_q <= in_gy;
			w_q <= cw;
			h_q <= ch;
		end
		if (state_q == S_START || ((state_q == S_NB && !nb_ok) || state_q == S_NBCMP)) begin
			scx_q <= '0;
			scy_q <= '0;
			sci_q <= '0;
		end else if (state_q == S_SCAN && !sc_end_q) begin
			x_s1 <= scx_q;
			y_s1 <= scy_q;
			sci_q <= sci_q + ((sci_q == IW'(CELLS - 1)) ? IW'(0) : IW'(1));
			if (int'(scx_q) == GRID_MAX_WIDTH - 1) begin
				scx_q <= '0;
				scy_q <= scy_q + COORD_W'(1);
			end else begin
				scx_q <= scx_q + COORD_W'(1);
			end
		end
		if (state_q == S_SCAN && vld_s1 && (!found_q || f_s1 < bestf_q)) begin
			bestf_q <= f_s1;
			bestg_q <= best_rd;
			curx_q <= x_s1;
			cury_q <= y_s1;
		end
		if (state_q == S_NB) begin
			nbx_q <= nbx;
			nby_q <= nby;
		end
		if (state_q == S_PICK) begin
			pcost_q <= bestg_q;
			tcur_q <= {gy_q, gx_q};
		end
		if (state_q == S_TRWAIT) tcur_q <= cf_rd;
		if (oload) begin
			if (state_q == S_NOPATH) begin
				odata_q <= '0;
				onopath_q <= 1'b1;
				olast_q <= 1'b1;
			end else begin
				odata_q <= {4'b0, pcost_q, stk_rd};
				onopath_q <= 1'b0;
				olast_q <= (ei_q == '0);
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata = odata_q;
	assign m_tuser = onopath_q;
	assign m_tlast = olast_q;

	`GASP_ASSERT(a_nopath_last, (m_tvalid && m_tuser) |-> m_tlast)
	`GASP_ASSERT_NEXT(a_search_busy, s_tvalid && s_tready && s_tuser == OP_SEARCH, !s_tready)
	`GASP_ASSERT_NEXT(a_empty_open, state_q == S_PICK && !found_q, state_q == S_NOPATH)
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import gasp_pkg::*;

	localparam int CELLS = 64;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct {
		logic [2:0]  x;
		logic [2:0]  y;
		logic [13:0] cost;
		logic        nopath;
		logic        last;
	} path_step_t;

	class path_scoreboard;
		logic [7:0]  cell_cost[CELLS];
		logic [3:0]  cols_reg;
		logic [3:0]  rows_reg;
		path_step_t  path_q[$];
		int          errors;

		function new();
			cols_reg = 8;
			rows_reg = 8;
			errors = 0;
			foreach (cell_cost[i]) cell_cost[i] = '0;
		endfunction

		function void note_config(logic idx, logic [3:0] v);
			if (idx == REG_WIDTH) cols_reg = v;
			else rows_reg = v;
		endfunction

		function int unsigned fit(logic [3:0] v);
			if (v == 0) return 1;
			if (v > 8) return 8;
			return v;
		endfunction

		function void push_step(int x, int y, int c, bit np, bit lst);
			path_step_t s;
			s.x = 3'(x); s.y = 3'(y); s.cost = 14'(c); s.nopath = np; s.last = lst;
			path_q = {path_q, s};
		endfunction

		// one accepted input transfer
		function void note_transfer(logic op, logic [2:0] sx, logic [2:0] sy,
				logic [7:0] c, logic [2:0] gx, logic [2:0] gy);
			int unsigned w, h, start, goal, cur, f, bestf, nb, g, cx, cy, n;
			int unsigned best[CELLS];
			int unsigned came[CELLS];
			bit open_set[CELLS];
			int unsigned trail[CELLS];
			bit found;
			if (op == OP_LOAD) begin
				cell_cost[sy * 8 + sx] = c;
				return;
			end
			w = fit(cols_reg);
			h = fit(rows_reg);
			if (sx >= w || sy >= h || gx >= w || gy >= h) begin
				push_step(0, 0, 0, 1, 1);
				return;
			end
			foreach (best[i]) begin
				best[i] = 14'h3fff;
				open_set[i] = 0;
				came[i] = 0;
			end
			start = sy * 8 + sx;
			goal = gy * 8 + gx;
			best[start] = cell_cost[start];
			came[start] = start;
			open_set[start] = 1;
			forever begin
				found = 0;
				bestf = 0;
				cur = 0;
				for (int i = 0; i < CELLS; i++) begin
					if (!open_set[i]) continue;
					f = best[i] + ((i % 8 > gx) ? i % 8 - gx : gx - i % 8)
						+ ((i / 8 > gy) ? i / 8 - gy : gy - i / 8);
					if (!found || f < bestf) begin
						found = 1;
						bestf = f;
						cur = i;
					end
				end
				if (!found) begin
					push_step(0, 0, 0, 1, 1);
					return;
				end
				if (cur == goal) break;
				open_set[cur] = 0;
				cx = cur % 8;
				cy = cur / 8;
				for (int d = 0; d < 4; d++) begin
					if (d == 0) begin
						if (cx + 1 >= w) continue;
						nb = cur + 1;
					end else if (d == 1) begin
						if (cy + 1 >= h) continue;
						nb = cur + 8;
					end else if (d == 2) begin
						if (cx == 0) continue;
						nb = cur - 1;
					end else begin
						if (cy == 0) continue;
						nb = cur - 8;
					end
					g = best[cur] + cell_cost[nb];
					if (g < best[nb]) begin
						best[nb] = g;
						came[nb] = cur;
						open_set[nb] = 1;
					end
				end
			end
			n = 0;
			cur = goal;
			forever begin
				trail[n] = cur;
				n++;
				if (cur == start || n >= CELLS) break;
				cur = came[cur];
			end
			for (int i = 0; i < n; i++)
				push_step(trail[n - 1 - i] % 8, trail[n - 1 - i] / 8, best[goal], 0,
					i + 1 == n);
		endfunction

		function void check_result(logic [23:0] d, logic np, logic lst);
			path_step_t e;
			if (path_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result tdata=%h tuser=%b tlast=%b", d, np, lst);
				return;
			end
			e = path_q.pop_front();
			if (d[2:0] !== e.x || d[5:3] !== e.y || d[19:6] !== e.cost
					|| np !== e.nopath || lst !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp x=%0d y=%0d cost=%0d np=%b last=%b, %s",
						e.x, e.y, e.cost, e.nopath, e.last,
						$sformatf("got x=%0d y=%0d cost=%0d np=%b last=%b",
							d[2:0], d[5:3], d[19:6], np, lst));
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we = 0;
	logic        cfg_index = 0;
	logic [3:0]  cfg_data = '0;

	path_scoreboard sb = new();
	bit     quiet = 0;
	int     hold_cnt = 0;
	longint cycles = 0;
	int     items = 0;

	always #1 clk = ~clk;

	grid_astar_path_search dut (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			hold_cnt = $urandom_range(0, 8);
			m_tready <= 0;
		end else
			m_tready <= 1;
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);

	task automatic send(logic op, logic [2:0] x, logic [2:0] y, logic [7:0] c,
			logic [2:0] gx, logic [2:0] gy);
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {4'b0, gy, gx, c, y, x};
		do @(posedge clk); while (!s_tready);
		sb.note_transfer(op, x, y, c, gx, gy);
		items++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.path_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.note_config(idx, v);
	endtask

	task automatic load_cell(int x, int y, logic [7:0] c);
		send(OP_LOAD, x, y, c, $urandom, $urandom);
	endtask

	task automatic search(int sx, int sy, int gx, int gy);
		send(OP_SEARCH, sx, sy, $urandom, gx, gy);
	endtask

	function automatic logic [3:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(1, 4);
		if (r < 8) return $urandom_range(5, 8);
		if (r == 8) return 0;
		return $urandom_range(9, 15);
	endfunction

	initial begin
		int w, h;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// fill the whole store first
		for (int i = 0; i < CELLS; i++)
			load_cell(i % 8, i / 8, (i == 0) ? 8'd255 : (i == 63) ? 8'd1 :
				(i % 17 == 5) ? 8'd0 : 8'($urandom_range(1, 255)));
		settle();

		search(3, 3, 3, 3);
		search(0, 0, 7, 7);
		search(7, 7, 0, 0);
		search(7, 0, 0, 7);
		settle();
		write_reg(REG_WIDTH, 4'd3);
		write_reg(REG_HEIGHT, 4'd2);
		search(0, 0, 2, 1);
		search(5, 0, 1, 1);
		search(0, 0, 0, 4);
		load_cell(6, 6, 8'd9);
		settle();
		write_reg(REG_WIDTH, 4'd0);
		write_reg(REG_HEIGHT, 4'd15);
		search(0, 0, 0, 7);
		search(0, 7, 1, 0);
		settle();
		write_reg(REG_WIDTH, 4'd1);
		write_reg(REG_HEIGHT, 4'd1);
		search(0, 0, 0, 0);
		settle();

		while (items < 220) begin
			if (items > 165) quiet = 1;
			w = pick_size();
			h = pick_size();
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			w = sb.fit(w);
			h = sb.fit(h);
			repeat ($urandom_range(8, 15)) begin
				if ($urandom_range(0, 2) == 0)
					load_cell($urandom_range(0, 7), $urandom_range(0, 7),
						($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
				else if ($urandom_range(0, 7) == 0)
					search($urandom_range(0, 7), $urandom_range(0, 7),
						$urandom_range(0, 7), $urandom_range(0, 7));
				else
					search($urandom_range(0, w - 1), $urandom_range(0, h - 1),
						$urandom_range(0, w - 1), $urandom_range(0, h - 1));
			end
			settle();
		end

		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.path_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
